@@ sv/nwc_pkg.sv @@
package nwc_pkg;

   // Calendar and field widths
   localparam int NWC_DAYS              = 7;
   localparam int NWC_SLOTS_PER_DAY_DEF = 4;
   localparam int WEEKDAY_W             = 3;
   localparam int SLOT_W                = 2;
   localparam int HOUR_W                = 5;
   localparam int MINUTE_W              = 6;
   localparam int LEAD_W                = 6;
   localparam int DAY_MASK_W            = 7;
   localparam int CSR_DATA_W            = 7;
   localparam int BUZZ_W                = 2;
   // Minute sums: minute + lead, minute + 60
   localparam int SUM_W                 = 7;

   localparam logic [SUM_W-1:0]  MINUTES_PER_HOUR  = 7'd60;
   localparam logic [HOUR_W-1:0] CHIME_FIRST_HOUR  = 5'd6;
   localparam logic [HOUR_W-1:0] CHIME_LAST_HOUR   = 5'd23;
   localparam logic [HOUR_W-1:0] LOUD_HOUR_MORNING = 5'd7;
   localparam logic [HOUR_W-1:0] LOUD_HOUR_NOON    = 5'd12;
   localparam logic [HOUR_W-1:0] LOUD_HOUR_EVENING = 5'd18;
   localparam logic [LEAD_W-1:0] LEAD_RESET        = 6'd5;

   typedef enum logic [0:0] {
      CSR_DAY_MASK     = 1'b0,
      CSR_LEAD_MINUTES = 1'b1
   } nwc_csr_index_type;

   typedef enum logic [0:0] {
      ACT_CHECK = 1'b0,
      ACT_WRITE = 1'b1
   } nwc_action_type;

   typedef enum logic [BUZZ_W-1:0] {
      BUZZ_SILENT = 2'd0,
      BUZZ_NORMAL = 2'd1,
      BUZZ_LOUD   = 2'd2
   } nwc_buzz_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DONE
   } nwc_state_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic                enable;
   } nwc_entry_type;

   localparam int ENTRY_W = $bits(nwc_entry_type);

endpackage

@@ sv/nwc_channels_if.sv @@
interface nwc_req_if
   import nwc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [WEEKDAY_W-1:0] weekday;
   logic [SLOT_W-1:0]    slot;
   logic [HOUR_W-1:0]    hour;
   logic [MINUTE_W-1:0]  minute;
   logic                 slot_enable;
   logic                 chime_enable;

   modport source (output valid, action, weekday, slot, hour, minute, slot_enable,
                   chime_enable, input ready);
   modport sink   (input valid, action, weekday, slot, hour, minute, slot_enable,
                   chime_enable, output ready);
endinterface

interface nwc_rsp_if
   import nwc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              upcoming;
   logic [BUZZ_W-1:0] buzz;

   modport source (output valid, upcoming, buzz, input ready);
   modport sink   (input valid, upcoming, buzz, output ready);
endinterface

interface nwc_csr_if
   import nwc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   nwc_csr_index_type     index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/nwc_ram.sv @@
module nwc_ram
   import nwc_pkg::*;
#(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = NWC_DAYS * NWC_SLOTS_PER_DAY_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/notification_window_checker_unit.sv @@
// Channel   Direction  Contents
// -------   ---------  -----------------------------------------------------------
// req_ch    in         action, weekday, slot, hour, minute, slot_enable, chime_enable
// rsp_ch    out        upcoming, buzz (one transfer for every request transfer)
// csr_ch    in         index (day_mask, lead_minutes), data; always ready
//
// Sequence: a write or a check of a disabled day goes from the transfer via ST_DONE to
// the response register; a check of an enabled day goes via ST_READ, then ST_EVAL for
// each of k slots scanned (1 to SLOTS_PER_DAY, one schedule RAM read per cycle), then
// ST_DONE. The next request is taken in the cycle after the response loads.
// Reset: synchronous, clears the slot valid bits (every slot reads as disabled),
// day_mask to 0 and lead_minutes to 5. No clearing pass is needed.
// Stalls: a response waits in its register while rsp_ch.ready is low; the block
// takes the next request meanwhile and holds only the following response.
module notification_window_checker_unit
   import nwc_pkg::*;
#(
   parameter int SLOTS_PER_DAY = NWC_SLOTS_PER_DAY_DEF
) (
   input  logic  clock,
   input  logic  reset,
   nwc_req_if.sink   req_ch,
   nwc_rsp_if.source rsp_ch,
   nwc_csr_if.sink   csr_ch
);

   localparam int DEPTH      = NWC_DAYS * SLOTS_PER_DAY;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
   localparam int SLOT_CMP_W = ($clog2(SLOTS_PER_DAY + 1) > SLOT_W) ?
                               $clog2(SLOTS_PER_DAY + 1) : SLOT_W;

   // Sequencer
   nwc_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // Item being worked on
   logic                action_ff, action_in;
   logic [HOUR_W-1:0]   hour_ff, hour_in;
   logic [MINUTE_W-1:0] minute_ff, minute_in;
   logic                chime_ff, chime_in;
   logic                upcoming_ff, upcoming_in;
   logic                signal_ff, signal_in;

   // Configuration
   logic [DAY_MASK_W-1:0] day_mask_ff, day_mask_in;
   logic [LEAD_W-1:0]     lead_ff, lead_in;

   // Slot valid bits, one per RAM entry
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic             valid_rd_ff, valid_rd_in;

   // Response register
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_upcoming_ff, rsp_upcoming_in;
   nwc_buzz_type rsp_buzz_ff, rsp_buzz_in;

   // RAM ports
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [ADDR_W-1:0] req_base;
   logic [ADDR_W-1:0] req_addr;
   nwc_entry_type ram_wr_data;
   nwc_entry_type ram_rd_data;

   logic          req_ready;
   logic          rsp_load;
   logic          day_ok;
   logic          slot_ok;
   logic          day_on;
   logic [DAY_MASK_W:0] mask_ext;

   // Slot evaluation
   logic             entry_on;
   logic             same_hour;
   logic             next_hour;
   logic             slot_sig;
   logic             slot_hit;
   logic             cnt_last;
   logic [SUM_W-1:0] now_plus_lead;
   logic [SUM_W-1:0] entry_plus_hour;

   // Chime
   logic         chime_ok;
   logic         loud_hour;
   nwc_buzz_type buzz_next;

   nwc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_schedule_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // Request decode: entry address of slot 0 of the day, and of the named slot
   assign req_base = ADDR_W'(ADDR_W'(req_ch.weekday) * ADDR_W'(SLOTS_PER_DAY));
   assign req_addr = ADDR_W'(req_base + ADDR_W'(req_ch.slot));
   assign day_ok   = (req_ch.weekday < WEEKDAY_W'(NWC_DAYS));
   assign slot_ok  = (SLOT_CMP_W'(req_ch.slot) < SLOT_CMP_W'(SLOTS_PER_DAY));
   // Weekday seven lands on the padding bit, which is always clear
   assign mask_ext = {1'b0, day_mask_ff};
   assign day_on   = mask_ext[req_ch.weekday];

   assign ram_wr_data.hour   = req_ch.hour;
   assign ram_wr_data.minute = req_ch.minute;
   assign ram_wr_data.enable = req_ch.slot_enable;

   // Window test on the slot whose read data just arrived
   assign entry_on        = valid_rd_ff && ram_rd_data.enable;
   assign same_hour       = (hour_ff == ram_rd_data.hour);
   assign next_hour       = ((HOUR_W + 1)'(hour_ff) + (HOUR_W + 1)'(1)) ==
                            (HOUR_W + 1)'(ram_rd_data.hour);
   assign now_plus_lead   = SUM_W'(minute_ff) + SUM_W'(lead_ff);
   assign entry_plus_hour = SUM_W'(ram_rd_data.minute) + MINUTES_PER_HOUR;
   assign slot_sig        = entry_on && same_hour && (ram_rd_data.minute == minute_ff);
   assign slot_hit        = entry_on &&
                            ((same_hour && (SUM_W'(ram_rd_data.minute) <= now_plus_lead) &&
                              (ram_rd_data.minute >= minute_ff)) ||
                             (!same_hour && next_hour && (entry_plus_hour < now_plus_lead)));
   assign cnt_last        = (cnt_ff == CNT_W'(SLOTS_PER_DAY - 1));

   // Chime from the held time and the first matching slot's signal
   assign chime_ok  = chime_ff && (hour_ff >= CHIME_FIRST_HOUR) &&
                      (hour_ff <= CHIME_LAST_HOUR) && (signal_ff || (minute_ff == '0));
   assign loud_hour = (hour_ff == LOUD_HOUR_MORNING) || (hour_ff == LOUD_HOUR_NOON) ||
                      (hour_ff == LOUD_HOUR_EVENING);

   always_comb begin
      if ((action_ff == ACT_WRITE) || !chime_ok) begin
         buzz_next = BUZZ_SILENT;
      end else if (loud_hour || signal_ff) begin
         buzz_next = BUZZ_LOUD;
      end else begin
         buzz_next = BUZZ_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer: writes go straight to the RAM at the transfer; checks read one
   // slot a cycle. Requests are held off during a scan, so a read never meets
   // a write to the same entry.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      addr_in     = addr_ff;
      action_in   = action_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      chime_in    = chime_ff;
      upcoming_in = upcoming_ff;
      signal_in   = signal_ff;
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               action_in   = req_ch.action;
               hour_in     = req_ch.hour;
               minute_in   = req_ch.minute;
               chime_in    = req_ch.chime_enable;
               upcoming_in = 1'b0;
               signal_in   = 1'b0;
               cnt_in      = '0;
               addr_in     = req_base;
               if (req_ch.action == ACT_WRITE) begin
                  // Drop writes to weekday seven or a slot past the day
                  ram_wr_en = day_ok && slot_ok;
                  state_in  = ST_DONE;
               end else if (day_on) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            addr_in   = ADDR_W'(addr_ff + ADDR_W'(1));
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            if (slot_hit || cnt_last) begin
               upcoming_in = slot_hit;
               signal_in   = slot_sig;
               state_in    = ST_DONE;
            end else begin
               // Fetch the next slot while this one is judged
               ram_rd_en = 1'b1;
               addr_in   = ADDR_W'(addr_ff + ADDR_W'(1));
               cnt_in    = CNT_W'(cnt_ff + CNT_W'(1));
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration, valid bits and response register next values
   always_comb begin
      day_mask_in = day_mask_ff;
      lead_in     = lead_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DAY_MASK:     day_mask_in = DAY_MASK_W'(csr_ch.data);
            CSR_LEAD_MINUTES: lead_in     = LEAD_W'(csr_ch.data);
            default: begin
               day_mask_in = day_mask_ff;
            end
         endcase
      end

      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[req_addr] = 1'b1;
      end
      valid_rd_in = ram_rd_en ? valid_ff[addr_ff] : valid_rd_ff;

      if (rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_upcoming_in = upcoming_ff;
         rsp_buzz_in     = buzz_next;
      end else begin
         rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
         rsp_upcoming_in = rsp_upcoming_ff;
         rsp_buzz_in     = rsp_buzz_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         day_mask_ff  <= '0;
         lead_ff      <= LEAD_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         day_mask_ff  <= day_mask_in;
         lead_ff      <= lead_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan registers
   always_ff @(posedge clock) begin
      cnt_ff          <= cnt_in;
      addr_ff         <= addr_in;
      action_ff       <= action_in;
      hour_ff         <= hour_in;
      minute_ff       <= minute_in;
      chime_ff        <= chime_in;
      upcoming_ff     <= upcoming_in;
      signal_ff       <= signal_in;
      valid_rd_ff     <= valid_rd_in;
      rsp_upcoming_ff <= rsp_upcoming_in;
      rsp_buzz_ff     <= rsp_buzz_in;
   end

   assign req_ch.ready    = req_ready;
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.upcoming = rsp_upcoming_ff;
   assign rsp_ch.buzz     = rsp_buzz_ff;

endmodule

@@ sv/nwc_checker.sv @@
module nwc_checker
   import nwc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_upcoming,
   input logic [BUZZ_W-1:0] rsp_buzz
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_upcoming) && $stable(rsp_buzz))
      else $error("response payload changed while stalled");

   // One request at a time: the cycle after a transfer takes no new request
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // Reset leaves no response pending and the request side open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind notification_window_checker_unit nwc_checker u_nwc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_upcoming (rsp_ch.upcoming),
   .rsp_buzz     (rsp_ch.buzz)
);
